FILE: rtl/core/mlq_pkg.sv
// Shared types and codes for the multilevel queue scheduler.
// Used by every module under rtl/core; depends on nothing else.
package mlq_pkg;

  localparam int LEVELS = 5;
  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int QSEL_W = 3;
  localparam int JOB_W = 16;
  localparam int ENTRY_W = JOB_W + 1;
  localparam int CNT_W = 32;
  localparam int NUM_CNT = 5;

  // Operation codes of an input item.
  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_REPORT   = 2'd2;

  // Status codes of a result item.
  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_DISPATCHED = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_BAD_CLASS  = 3'd4;

  // Counter order.
  localparam int CNT_JOBS   = 0;
  localparam int CNT_TOP    = 1;
  localparam int CNT_MIDDLE = 2;
  localparam int CNT_BOTTOM = 3;
  localparam int CNT_SWITCH = 4;

  typedef logic [NUM_CNT-1:0][CNT_W-1:0] counters_t;

  // Request from the decoder to the queue store.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [QSEL_W-1:0]  qsel;
    logic [ENTRY_W-1:0] entry;
  } queue_req_t;

  // Per-queue occupancy flags from the queue store.
  typedef struct packed {
    logic [LEVELS-1:0] empty;
    logic [LEVELS-1:0] full;
  } queue_flags_t;

endpackage

FILE: rtl/core/mlq_classify.sv
// Decodes one item: maps a submit to its queue, picks the queue a dispatch pops from,
// and forms the status. Depends on mlq_pkg.
module mlq_classify (
  input  logic [1:0]                    operation,
  input  logic [mlq_pkg::JOB_W-1:0]     job_id,
  input  logic [2:0]                    job_class,
  input  logic [2:0]                    job_priority,
  input  logic                          was_stopped,
  input  mlq_pkg::queue_flags_t         flags,
  output mlq_pkg::queue_req_t           req,
  output logic [2:0]                    status
);

  logic [mlq_pkg::QSEL_W-1:0] level;
  logic                       level_ok;
  logic [mlq_pkg::QSEL_W-1:0] pick;
  logic                       found;

  // Submit mapping, as a zero-based queue index.
  always_comb begin
    level    = '0;
    level_ok = 1'b1;
    if (job_class inside {3'd1, 3'd4, 3'd5}) begin
      level = job_class - 3'd1;
    end else if (job_class == 3'd2) begin
      if (job_priority == 3'd2) begin
        level = 3'd2;
      end else if (job_priority == 3'd3) begin
        level = 3'd3;
      end else begin
        level = 3'd1;
      end
    end else if (job_class == 3'd3) begin
      level = 3'd4;
    end else begin
      level_ok = 1'b0;
    end
  end

  // Lowest-numbered queue that holds a job.
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = mlq_pkg::LEVELS - 1; i >= 0; i--) begin
      if (!flags.empty[i]) begin
        pick  = mlq_pkg::QSEL_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    req       = '0;
    req.entry = {1'b0, job_id};
    status    = mlq_pkg::ST_ACCEPTED;
    case (operation)
      mlq_pkg::OP_SUBMIT: begin
        req.qsel = level;
        if (!level_ok) begin
          status = mlq_pkg::ST_BAD_CLASS;
        end else if (flags.full[level]) begin
          status = mlq_pkg::ST_FULL;
        end else begin
          req.push = 1'b1;
        end
      end
      mlq_pkg::OP_DISPATCH: begin
        req.qsel = pick;
        if (!found) begin
          status = mlq_pkg::ST_EMPTY;
        end else begin
          req.pop = 1'b1;
          status  = mlq_pkg::ST_DISPATCHED;
        end
      end
      mlq_pkg::OP_REPORT: begin
        // A stopped job goes back to the tail of the top queue as resumed.
        req.entry = {1'b1, job_id};
        if (was_stopped) begin
          if (flags.full[0]) begin
            status = mlq_pkg::ST_FULL;
          end else begin
            req.push = 1'b1;
          end
        end
      end
      default: begin
        status = mlq_pkg::ST_ACCEPTED;
      end
    endcase
  end

endmodule

FILE: rtl/core/mlq_queue_store.sv
// Five circular FIFOs sharing one slot memory, with head, tail and fill per queue.
// The popped entry is registered onto rd_entry in the cycle after the pop. Depends on mlq_pkg.
module mlq_queue_store #(
  parameter int QUEUE_DEPTH = mlq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mlq_pkg::queue_req_t           req,
  output mlq_pkg::queue_flags_t         flags,
  output logic [mlq_pkg::ENTRY_W-1:0]   rd_entry
);

  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = mlq_pkg::LEVELS * QUEUE_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] DEPTH_A  = AW'(QUEUE_DEPTH);

  logic [PW-1:0] heads [mlq_pkg::LEVELS];
  logic [PW-1:0] tails [mlq_pkg::LEVELS];
  logic [FW-1:0] fill  [mlq_pkg::LEVELS];
  logic [mlq_pkg::ENTRY_W-1:0] slots [SLOTS];

  logic [PW-1:0] head_sel;
  logic [PW-1:0] tail_sel;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic [AW-1:0] base;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign head_sel  = heads[req.qsel];
  assign tail_sel  = tails[req.qsel];
  assign head_next = (head_sel == LAST_PTR) ? '0 : head_sel + PW'(1);
  assign tail_next = (tail_sel == LAST_PTR) ? '0 : tail_sel + PW'(1);
  assign base      = AW'(req.qsel) * DEPTH_A;
  assign wr_addr   = base + AW'(tail_sel);
  assign rd_addr   = base + AW'(head_sel);

  always_comb begin
    for (int q = 0; q < mlq_pkg::LEVELS; q++) begin
      flags.empty[q] = (fill[q] == '0);
      flags.full[q]  = (fill[q] == FULL_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < mlq_pkg::LEVELS; q++) begin
        heads[q] <= '0;
        tails[q] <= '0;
        fill[q]  <= '0;
      end
    end else if (req.push) begin
      tails[req.qsel] <= tail_next;
      fill[req.qsel]  <= fill[req.qsel] + FW'(1);
    end else if (req.pop) begin
      heads[req.qsel] <= head_next;
      fill[req.qsel]  <= fill[req.qsel] - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      slots[wr_addr] <= req.entry;
    end
    if (req.pop) begin
      rd_entry <= slots[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mlq_counters.sv
// Saturating dispatch counters, bumped as a dispatch result is loaded for output.
// Depends on mlq_pkg.
module mlq_counters (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        bump,
  input  logic [mlq_pkg::QSEL_W-1:0]  qsel,
  input  logic                        resumed,
  output mlq_pkg::counters_t          counts
);

  logic [mlq_pkg::NUM_CNT-1:0] hit;

  always_comb begin
    hit = '0;
    hit[mlq_pkg::CNT_SWITCH] = 1'b1;
    if (qsel == '0) begin
      // A resumed job in the top queue is not a fresh start.
      hit[mlq_pkg::CNT_JOBS] = !resumed;
      hit[mlq_pkg::CNT_TOP]  = !resumed;
    end else if (qsel <= 3'd3) begin
      hit[mlq_pkg::CNT_JOBS]   = 1'b1;
      hit[mlq_pkg::CNT_MIDDLE] = 1'b1;
    end else begin
      hit[mlq_pkg::CNT_JOBS]   = 1'b1;
      hit[mlq_pkg::CNT_BOTTOM] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (bump) begin
      for (int i = 0; i < mlq_pkg::NUM_CNT; i++) begin
        if (hit[i] && (counts[i] != '1)) begin
          counts[i] <= counts[i] + mlq_pkg::CNT_W'(1);
        end
      end
    end
  end

endmodule

FILE: rtl/core/multilevel_queue_scheduler.sv
// Multilevel queue scheduler top level: decoder, queue store, counters and result pipeline.
// Depends on mlq_pkg, mlq_classify, mlq_queue_store and mlq_counters.
//
// Input channel (in_valid / in_stall) carries one operation per item: submit a
// job, dispatch the next job, or report the end of a slice. Output channel
// (out_valid / out_stall) returns exactly one result item per input item, in order.
// Queue state is updated at the edge an item is accepted; the popped slot is read
// from the slot memory on that same edge, so the result passes the memory read
// register and then the output register before it leaves.
// Throughput is one item per cycle while out_stall is low: the slot memory takes one
// write or one read per item, and the stage after it is the only place a stall can
// back up into. When the receiver stalls, the output register holds its result and
// one more item can be accepted into the middle stage; after that in_stall rises.
// Counter fields show the totals after the item that the result belongs to.
// Reset empties all five queues and clears the counters; the slot memory is not
// cleared, since only entries that were written are ever read.
module multilevel_queue_scheduler #(
  parameter int QUEUE_DEPTH = mlq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     operation,
  input  logic [mlq_pkg::JOB_W-1:0]      job_id,
  input  logic [2:0]                     job_class,
  input  logic [2:0]                     job_priority,
  input  logic                           was_stopped,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [mlq_pkg::JOB_W-1:0]      out_job,
  output logic [2:0]                     out_queue,
  output logic                           out_resumed,
  output logic                           needs_slice,
  output logic [mlq_pkg::CNT_W-1:0]      jobs_started,
  output logic [mlq_pkg::CNT_W-1:0]      top_started,
  output logic [mlq_pkg::CNT_W-1:0]      middle_started,
  output logic [mlq_pkg::CNT_W-1:0]      bottom_started,
  output logic [mlq_pkg::CNT_W-1:0]      switches
);

  mlq_pkg::queue_req_t   req;
  mlq_pkg::queue_req_t   req_gated;
  mlq_pkg::queue_flags_t flags;
  mlq_pkg::counters_t    counts;
  logic [2:0]                      status_comb;
  logic [mlq_pkg::ENTRY_W-1:0]     rd_entry;
  logic                            accept;
  logic                            adv;
  logic                            dispatched;

  // Middle stage: decode results waiting for the slot read.
  logic                            valid1;
  logic [2:0]                      status1;
  logic [mlq_pkg::QSEL_W-1:0]      qsel1;

  mlq_classify u_classify (
    .operation    (operation),
    .job_id       (job_id),
    .job_class    (job_class),
    .job_priority (job_priority),
    .was_stopped  (was_stopped),
    .flags        (flags),
    .req          (req),
    .status       (status_comb)
  );

  always_comb begin
    req_gated      = req;
    req_gated.push = req.push && accept;
    req_gated.pop  = req.pop && accept;
  end

  mlq_queue_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req_gated),
    .flags    (flags),
    .rd_entry (rd_entry)
  );

  assign adv        = valid1 && (!out_valid || !out_stall);
  assign in_stall   = valid1 && !adv;
  assign accept     = in_valid && !in_stall;
  assign dispatched = (status1 == mlq_pkg::ST_DISPATCHED);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (accept) begin
      valid1 <= 1'b1;
    end else if (adv) begin
      valid1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status1 <= status_comb;
      qsel1   <= req.qsel;
    end
  end

  mlq_counters u_counters (
    .clk     (clk),
    .rst     (rst),
    .bump    (adv && dispatched),
    .qsel    (qsel1),
    .resumed (rd_entry[mlq_pkg::JOB_W]),
    .counts  (counts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status      <= status1;
      out_job     <= dispatched ? rd_entry[mlq_pkg::JOB_W-1:0] : '0;
      out_queue   <= dispatched ? qsel1 + 3'd1 : 3'd0;
      out_resumed <= dispatched && rd_entry[mlq_pkg::JOB_W];
      needs_slice <= dispatched && (qsel1 == '0);
    end
  end

  // The counters only change when the output register loads, so they read out directly.
  assign jobs_started   = counts[mlq_pkg::CNT_JOBS];
  assign top_started    = counts[mlq_pkg::CNT_TOP];
  assign middle_started = counts[mlq_pkg::CNT_MIDDLE];
  assign bottom_started = counts[mlq_pkg::CNT_BOTTOM];
  assign switches       = counts[mlq_pkg::CNT_SWITCH];

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != mlq_pkg::ST_DISPATCHED) |->
      (out_job == '0) && (out_queue == 3'd0) && !out_resumed && !needs_slice)
    else $error("non-dispatch result carries dispatch fields");

  a_dispatch_queue: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mlq_pkg::ST_DISPATCHED) |->
      (out_queue >= 3'd1) && (out_queue <= 3'd5) && (needs_slice == (out_queue == 3'd1)))
    else $error("dispatch result has a bad queue or slice flag");

  a_counter_order: assert property (@(posedge clk) disable iff (rst)
    (top_started <= jobs_started) && (jobs_started <= switches))
    else $error("dispatch counters out of order");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> valid1 && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

endmodule
